// ===== rtl/hmac_ctr_keystream_xor_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef HMAC_CTR_KEYSTREAM_XOR_MACROS_SVH
`define HMAC_CTR_KEYSTREAM_XOR_MACROS_SVH
`define HCK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HCK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/hck_pkg.sv =====
// Package for the HMAC-SHA256 counter keystream block: types, constants, SHA functions.
// No dependencies.
`default_nettype none
package hck_pkg;
    localparam int unsigned CfgWidth = 64;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned BlockBytes = 32;
    localparam int unsigned NonceBytes = 16;
    localparam int unsigned OffWidth = 5;
    localparam int unsigned CtrWidth = 64;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_KEY0 = 3'd0, REG_KEY1 = 3'd1, REG_KEY2 = 3'd2, REG_KEY3 = 3'd3,
        REG_NONCE_LOW = 3'd4, REG_NONCE_HIGH = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_ROUND, ST_FINISH, ST_OUTPUT
    } state_t;

    // Which 64-byte SHA block the datapath loads
    typedef enum logic [1:0] {
        BLK_IPAD, BLK_INNER_TAIL, BLK_OPAD, BLK_OUTER_TAIL
    } blk_sel_t;

    typedef struct packed {
        logic     load;      // load message block, init or keep chaining value
        logic     init_h;
        blk_sel_t blk;
        logic     round;
        logic     finish;    // add working vars into chaining value
        logic     save_inner;
        logic     save_ks;
    } dp_cmd_t;

    typedef struct packed {
        logic round_last;
    } dp_sts_t;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [255:0] InitH = {
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [63:0] bswap64(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/hck_stream_if.sv =====
// Valid/ready stream interface carrying a byte and a last flag.
// No dependencies.
`default_nettype none
interface hck_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    logic       last;
    modport source (output valid, output data, output last, input ready);
    modport sink (input valid, input data, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/hck_datapath.sv =====
// SHA-256 datapath: message schedule, working variables, chaining value, keystream.
// Depends on hck_pkg.
`default_nettype none
module hck_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hck_pkg::dp_cmd_t    cmd,
    output hck_pkg::dp_sts_t         sts,
    input  wire logic [255:0]        key,
    input  wire logic [127:0]        nonce,
    input  wire logic [63:0]         counter,
    input  wire logic [4:0]          rd_off,
    output logic [7:0]               ks_byte
);
    import hck_pkg::*;

    logic [511:0] w_reg, w_next;
    logic [255:0] h_reg, h_next;
    logic [255:0] v_reg, v_next;
    logic [255:0] inner_reg;
    logic [255:0] ks_reg;
    logic [5:0]   rnd_reg, rnd_next;
    logic [255:0] kx36, kx5c, key_be;
    logic [511:0] blk;

    always_comb
    begin
        // key bytes in message order: byte 0 first (most significant)
        for (int i = 0; i < 32; i++)
        begin
            key_be[255-8*i -: 8] = key[8*i +: 8];
        end
        kx36 = key_be ^ {32{8'h36}};
        kx5c = key_be ^ {32{8'h5c}};
        case (cmd.blk)
            BLK_IPAD:       blk = {kx36, {32{8'h36}}};
            BLK_INNER_TAIL: blk = {bswap64(nonce[63:0]), bswap64(nonce[127:64]),
                                   bswap64(counter), 8'h80, 248'd0, 64'd704};
            BLK_OPAD:       blk = {kx5c, {32{8'h5c}}};
            BLK_OUTER_TAIL: blk = {inner_reg, 8'h80, 184'd0, 64'd768};
            default:        blk = '0;
        endcase
    end

    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1, wn;

    always_comb
    begin
        {a, b, c, d, e, f, g, hh} = v_reg;
        t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + RoundK[rnd_reg] + w_reg[511:480];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        s0 = rotr(w_reg[479:448], 7) ^ rotr(w_reg[479:448], 18) ^ (w_reg[479:448] >> 3);
        s1 = rotr(w_reg[63:32], 17) ^ rotr(w_reg[63:32], 19) ^ (w_reg[63:32] >> 10);
        wn = w_reg[511:480] + s0 + w_reg[223:192] + s1;
        w_next = w_reg;
        v_next = v_reg;
        h_next = h_reg;
        rnd_next = rnd_reg;
        if (cmd.load)
        begin
            w_next = blk;
            h_next = cmd.init_h ? InitH : h_reg;
            v_next = cmd.init_h ? InitH : h_reg;
            rnd_next = '0;
        end
        else if (cmd.round)
        begin
            w_next = {w_reg[479:0], wn};
            v_next = {t1 + t2, a, b, c, d + t1, e, f, g};
            rnd_next = rnd_reg + 6'd1;
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[32*i +: 32] = h_reg[32*i +: 32] + v_reg[32*i +: 32];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg <= '0;
        end
        else
        begin
            rnd_reg <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
        h_reg <= h_next;
        if (cmd.save_inner)
        begin
            inner_reg <= h_reg;
        end
        if (cmd.save_ks)
        begin
            ks_reg <= h_reg;
        end
    end

    assign sts.round_last = (rnd_reg == 6'd63);
    assign ks_byte = cmd.save_ks ? h_reg[255 - 8*rd_off -: 8] : ks_reg[255 - 8*rd_off -: 8];
endmodule
`default_nettype wire

// ===== rtl/hck_controller.sv =====
// Controller: sequences the four compressions and the byte handshake.
// Depends on hck_pkg.
`default_nettype none
module hck_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output hck_pkg::dp_cmd_t      cmd,
    input  wire hck_pkg::dp_sts_t sts,
    output logic [63:0]           counter,
    output logic [4:0]            offset,
    output logic                  capture
);
    import hck_pkg::*;

    state_t     state_reg, state_next;
    blk_sel_t   blk_reg, blk_next;
    logic [63:0] ctr_reg, ctr_next;
    logic [4:0]  off_reg, off_next;
    logic        last_reg, last_next;
    logic        ov_reg, ov_next;

    wire accept = in_valid && in_ready;

    function automatic blk_sel_t blk_t_inc(input blk_sel_t x);
        case (x)
            BLK_IPAD:       return BLK_INNER_TAIL;
            BLK_INNER_TAIL: return BLK_OPAD;
            BLK_OPAD:       return BLK_OUTER_TAIL;
            default:        return BLK_IPAD;
        endcase
    endfunction

    always_comb
    begin
        state_next = state_reg;
        blk_next = blk_reg;
        ctr_next = ctr_reg;
        off_next = off_reg;
        last_next = last_reg;
        ov_next = ov_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = in_last;
                    if (off_reg == '0)
                    begin
                        blk_next = BLK_IPAD;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_OUTPUT;
                    end
                end
            end
            ST_LOAD:   state_next = ST_ROUND;
            ST_ROUND:  if (sts.round_last) state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (blk_reg == BLK_OUTER_TAIL)
                begin
                    state_next = ST_OUTPUT;
                    ctr_next = ctr_reg + 64'd1;
                end
                else
                begin
                    blk_next = blk_t_inc(blk_reg);
                    state_next = ST_LOAD;
                end
            end
            ST_OUTPUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    off_next = off_reg + 5'd1;
                    if (last_reg)
                    begin
                        off_next = '0;
                        ctr_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.blk = blk_reg;
        in_ready = 1'b0;
        capture = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                cmd.init_h = (blk_reg == BLK_IPAD) || (blk_reg == BLK_OPAD);
            end
            ST_ROUND:  cmd.round = 1'b1;
            ST_FINISH: cmd.finish = 1'b1;
            ST_OUTPUT: capture = !ov_reg || out_ready;
            default:   cmd = '0;
        endcase
        // chaining value is final in the cycle after finish
        cmd.save_inner = (state_reg == ST_LOAD) && (blk_reg == BLK_OPAD);
        cmd.save_ks = (state_reg == ST_OUTPUT) && (off_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            blk_reg <= BLK_IPAD;
            ctr_reg <= '0;
            off_reg <= '0;
            last_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            blk_reg <= blk_next;
            ctr_reg <= ctr_next;
            off_reg <= off_next;
            last_reg <= last_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign counter = ctr_reg;
    assign offset = off_reg;
endmodule
`default_nettype wire

// ===== rtl/hmac_ctr_keystream_xor.sv =====
// HMAC-SHA256 counter keystream XOR cipher, top level.
// Depends on hck_pkg, hck_stream_if, hck_controller, hck_datapath.
//
// Usage: bytes enter on in_s (data, last) and leave on out_s (data XOR keystream, last).
// Six 64-bit registers (key words 0-3, nonce low/high) are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the block is idle,
// which the block itself does not enforce. Unknown indexes are ignored.
// A byte that opens a keystream block (offset 0) runs four SHA-256 compressions
// in the shared round unit before its result is written to the output register.
// The 31 other bytes of the block go to the output register without a compression.
// A new byte is taken only once the last one has reached the output register.
// The result sits in an output register; the next byte is accepted while it
// waits, and a stall holds the block until the register frees.
// Reset clears counter, offset and control; key and nonce reset to zero.
// last set on a byte resets counter and offset for the next blob.
`default_nettype none
module hmac_ctr_keystream_xor (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    hck_stream_if.sink                         in_s,
    hck_stream_if.source                       out_s,
    input  wire logic                          cfg_we,
    input  wire logic [hck_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [hck_pkg::CfgWidth-1:0]  cfg_wdata
);
    import hck_pkg::*;

    logic [255:0] key_reg;
    logic [127:0] nonce_reg;
    dp_cmd_t      cmd;
    dp_sts_t      sts;
    logic [63:0]  counter;
    logic [4:0]   offset;
    logic         capture;
    logic [7:0]   ks_byte;
    logic [7:0]   data_reg, obyte_reg;
    logic         dlast_reg;
    logic         olast_reg;
    logic         out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            nonce_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY0:       key_reg[63:0] <= cfg_wdata;
                REG_KEY1:       key_reg[127:64] <= cfg_wdata;
                REG_KEY2:       key_reg[191:128] <= cfg_wdata;
                REG_KEY3:       key_reg[255:192] <= cfg_wdata;
                REG_NONCE_LOW:  nonce_reg[63:0] <= cfg_wdata;
                REG_NONCE_HIGH: nonce_reg[127:64] <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    hck_controller u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_s.valid), .in_last(in_s.last), .in_ready(in_s.ready),
        .out_valid(out_valid), .out_ready(out_s.ready),
        .cmd(cmd), .sts(sts), .counter(counter), .offset(offset), .capture(capture)
    );

    hck_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .key(key_reg),
        .nonce(nonce_reg), .counter(counter), .rd_off(offset), .ks_byte(ks_byte)
    );

    logic [7:0] ks_sel;
    // keystream register loads the same cycle at offset 0; bypass it
    assign ks_sel = ks_byte;

    always_ff @(posedge clk)
    begin
        if (in_s.valid && in_s.ready)
        begin
            data_reg <= in_s.data;
            dlast_reg <= in_s.last;
        end
        if (capture)
        begin
            obyte_reg <= data_reg ^ ks_sel;
            olast_reg <= dlast_reg;
        end
    end

    assign out_s.valid = out_valid;
    assign out_s.data = obyte_reg;
    assign out_s.last = olast_reg;
endmodule
`default_nettype wire

// ===== rtl/hck_checker.sv =====
// Port-level checker for hmac_ctr_keystream_xor, bound to the top level.
// Depends on hmac_ctr_keystream_xor_macros.svh.
`default_nettype none
`include "hmac_ctr_keystream_xor_macros.svh"
module hck_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready
);
    `HCK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `HCK_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
    `HCK_ASSERT_IMPL(a_out_after, clk, rst_n, $rose(out_valid), !in_ready || $past(in_ready) == 1'b0)
endmodule
bind hmac_ctr_keystream_xor hck_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_s.valid), .in_ready(in_s.ready),
    .out_valid(out_s.valid), .out_ready(out_s.ready)
);
`default_nettype wire
